// ===== rtl/kem_pkg.sv =====
// kem_pkg: types and constants for the key edge event mapper
// no dependencies; imported by key_edge_event_mapper and kem_checker

package kem_pkg;

  localparam int unsigned KeyCount  = 7;
  localparam int unsigned HeldBits  = 6;
  localparam int unsigned CodeBits  = 6;
  localparam int unsigned StampBits = 32;
  localparam int unsigned SlotBits  = 6;

  // packed stream widths, padded to whole bytes
  localparam int unsigned InDataBits  = 40;
  localparam int unsigned OutDataBits = 56;

  // event ids
  localparam logic [CodeBits-1:0] EvUp      = 6'd1;
  localparam logic [CodeBits-1:0] EvDown    = 6'd3;
  localparam logic [CodeBits-1:0] EvLeft    = 6'd2;
  localparam logic [CodeBits-1:0] EvRight   = 6'd4;
  localparam logic [CodeBits-1:0] EvJump    = 6'd7;
  localparam logic [CodeBits-1:0] EvConfirm = 6'h24;

  typedef logic [KeyCount-1:0] keys_t;

  // event id per key bit, up to Return
  typedef logic [CodeBits-1:0] code_tab_t [KeyCount];
  localparam code_tab_t EventIds = '{EvUp, EvDown, EvLeft, EvRight, EvJump,
                                     EvConfirm, EvConfirm};

  // one result as it leaves the block
  typedef struct packed {
    logic [SlotBits-1:0]  event_slot;
    logic [StampBits-1:0] event_stamp;
    logic                 event_pressed;
    logic [CodeBits-1:0]  event_code;
    logic                 event_valid;
    logic [HeldBits-1:0]  held_mask;
  } result_t;

endpackage

// ===== rtl/key_edge_event_mapper.sv =====
// key_edge_event_mapper: key edge detector posting one event per changed key
// depends on kem_pkg
//
//  channel  dir  tdata fields (low bit up)            tlast          tuser
//  s_axis   in   keys_down[6:0], frame_time[38:7]     -              -
//  m_axis   out  held_mask, event_valid, event_code,  last_of_frame  -
//                event_pressed, event_stamp, event_slot
//
// a frame yields one result per changed key, or one result when nothing changed
// (1 to 7 results); the result register emits one result per cycle unless m_axis
// stalls, and the next frame is taken in the cycle its predecessor's last result is loaded.
// reset clears the previous keys, the started flag and the slot pointer.
// a stall on m_axis holds the result register and the pending key mask.

module key_edge_event_mapper #(
  parameter int unsigned RING_SLOTS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // keys_down[6:0], frame_time[38:7], zero pad
  input  logic [kem_pkg::InDataBits-1:0] s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // held_mask[5:0], event_valid[6], event_code[12:7], event_pressed[13],
  // event_stamp[45:14], event_slot[51:46], zero pad
  output logic [kem_pkg::OutDataBits-1:0] m_axis_tdata,
  output logic                           m_axis_tlast
);
  import kem_pkg::*;

  localparam int unsigned PtrBits = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam logic [PtrBits-1:0] PtrLast = PtrBits'(RING_SLOTS - 1);

  logic                 busy_q, busy_d;
  keys_t                keys_q, prev_q, pend_q, pend_d;
  logic [StampBits-1:0] stamp_q;
  logic                 started_q;
  logic [PtrBits-1:0]   ptr_q, ptr_d;
  logic                 out_valid_q;
  result_t              res_q, res_d;
  logic                 res_last_q, last_d;

  logic                 load_ok, emit, s_acc;
  keys_t                in_keys, pick, pend_rest;
  logic [2:0]           pick_idx;

  assign in_keys = s_axis_tdata[KeyCount-1:0];
  assign load_ok = !out_valid_q || m_axis_tready;
  assign emit    = busy_q && load_ok;

  // lowest pending key
  always_comb begin
    pick     = '0;
    pick_idx = '0;
    for (int k = KeyCount - 1; k >= 0; k--) begin
      if (pend_q[k]) begin
        pick     = '0;
        pick[k]  = 1'b1;
        pick_idx = 3'(k);
      end
    end
    pend_rest = pend_q & ~pick;
  end

  assign last_d        = (pend_rest == '0);
  assign s_axis_tready = !busy_q || (load_ok && last_d);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // result build and slot advance
  always_comb begin
    res_d           = '0;
    res_d.held_mask = keys_q[HeldBits-1:0];
    ptr_d           = ptr_q;
    if (pend_q != '0) begin
      res_d.event_valid   = 1'b1;
      res_d.event_code    = EventIds[pick_idx];
      res_d.event_pressed = |(keys_q & pick);
      res_d.event_stamp   = stamp_q;
      res_d.event_slot    = SlotBits'(ptr_q);
      ptr_d               = (ptr_q == PtrLast) ? '0 : ptr_q + 1'b1;
    end
  end

  // frame stage next state
  always_comb begin
    busy_d = busy_q;
    pend_d = pend_q;
    if (emit) begin
      pend_d = pend_rest;
      if (last_d) busy_d = 1'b0;
    end
    if (s_acc) begin
      busy_d = 1'b1;
      pend_d = started_q ? (in_keys ^ prev_q) : '0;
    end
  end

  // frame stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      pend_q    <= '0;
      prev_q    <= '0;
      started_q <= 1'b0;
      ptr_q     <= '0;
    end else begin
      busy_q <= busy_d;
      pend_q <= pend_d;
      if (emit) ptr_q <= ptr_d;
      if (s_acc) begin
        prev_q    <= in_keys;
        started_q <= 1'b1;
      end
    end
  end

  // frame stage payload
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      keys_q  <= in_keys;
      stamp_q <= s_axis_tdata[KeyCount +: StampBits];
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_ok) begin
      out_valid_q <= busy_q;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q      <= res_d;
      res_last_q <= last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataBits'(res_q);
  assign m_axis_tlast  = res_last_q;

endmodule

// ===== rtl/kem_checker.sv =====
// kem_checker: port-level assertions for key_edge_event_mapper
// depends on kem_pkg; bound to key_edge_event_mapper below

module kem_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [kem_pkg::InDataBits-1:0]  s_axis_tdata,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [kem_pkg::OutDataBits-1:0] m_axis_tdata,
  input logic                            m_axis_tlast
);
  import kem_pkg::*;

  result_t res;
  assign res = s_axis_tvalid ? result_t'(m_axis_tdata[$bits(result_t)-1:0])
                             : result_t'(m_axis_tdata[$bits(result_t)-1:0]);

  // a stalled result keeps its valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output payload changed while stalled");

  // a result without an event is marked as the last result of its frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res.event_valid |-> m_axis_tlast)
    else $error("empty result not marked last");

  // an empty result carries zero event fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res.event_valid |->
      res.event_code == '0 && !res.event_pressed && res.event_stamp == '0
      && res.event_slot == '0)
    else $error("empty result has nonzero event fields");

  // results of one frame share the held mask and the stamp
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid |->
      res.held_mask == $past(res.held_mask) && res.event_stamp == $past(res.event_stamp))
    else $error("frame fields differ within one frame");

endmodule

bind key_edge_event_mapper kem_checker u_kem_checker (.*);

// ===== tb/key_edge_event_mapper_tb.sv =====
// key_edge_event_mapper_tb: self-checking stream testbench for the key edge event mapper
// a scoreboard class predicts the events of each frame and checks results in order
// depends on kem_pkg and rtl/key_edge_event_mapper.sv
`timescale 1ns / 100ps

module key_edge_event_mapper_tb;

  import kem_pkg::*;

  localparam int unsigned RingSlots   = 64;
  localparam int unsigned ClkPeriod   = 20;
  localparam int unsigned ResetCycles = 10;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned RandBlocks  = 8;
  localparam int unsigned BlockFrames = 39;

  // one expected result and its frame marker
  typedef struct {
    result_t res;
    logic    last;
  } expected_event_t;

  // predicts posted events per frame and checks results in arrival order
  class key_event_scoreboard;
    keys_t           prior_keys;
    bit              seen_frame;
    int unsigned     next_slot;
    int unsigned     ring_size;
    expected_event_t posted[$];
    int              errors;

    function new(int unsigned slots);
      prior_keys = '0;
      seen_frame = 1'b0;
      next_slot  = 0;
      ring_size  = slots;
      errors     = 0;
    endfunction

    function void fault(string what, logic [63:0] want, logic [63:0] got);
      errors++;
      if (errors <= 10) begin
        $display("%0t mismatch %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
      end
    endfunction

    // accepted frame: queue one result per changed key, or one empty result
    function void note_frame(keys_t keys, logic [StampBits-1:0] stamp);
      keys_t           flips;
      expected_event_t ev;
      int              queued_before;
      queued_before = posted.size();
      flips = seen_frame ? (keys ^ prior_keys) : '0;
      for (int k = 0; k < KeyCount; k++) begin
        if (flips[k]) begin
          ev.res               = '0;
          ev.res.held_mask     = keys[HeldBits-1:0];
          ev.res.event_valid   = 1'b1;
          ev.res.event_code    = EventIds[k];
          ev.res.event_pressed = keys[k];
          ev.res.event_stamp   = stamp;
          ev.res.event_slot    = next_slot[SlotBits-1:0];
          ev.last              = 1'b0;
          posted.push_back(ev);
          next_slot = (next_slot + 1) % ring_size;
        end
      end
      // no edge, or first frame after reset
      if (posted.size() == queued_before) begin
        ev.res           = '0;
        ev.res.held_mask = keys[HeldBits-1:0];
        ev.last          = 1'b0;
        posted.push_back(ev);
      end
      ev = posted.pop_back();
      ev.last = 1'b1;
      posted.push_back(ev);
      prior_keys = keys;
      seen_frame = 1'b1;
    endfunction

    // accepted result: compare field by field with the oldest expectation
    function void check_result(logic [OutDataBits-1:0] data, logic last);
      result_t         got;
      expected_event_t want;
      got = data[$bits(result_t)-1:0];
      if (posted.size() == 0) begin
        fault("result without pending frame", '0, data);
        return;
      end
      want = posted.pop_front();
      if (got.held_mask !== want.res.held_mask)
        fault("held_mask", want.res.held_mask, got.held_mask);
      if (got.event_valid !== want.res.event_valid)
        fault("event_valid", want.res.event_valid, got.event_valid);
      if (got.event_code !== want.res.event_code)
        fault("event_code", want.res.event_code, got.event_code);
      if (got.event_pressed !== want.res.event_pressed)
        fault("event_pressed", want.res.event_pressed, got.event_pressed);
      if (got.event_stamp !== want.res.event_stamp)
        fault("event_stamp", want.res.event_stamp, got.event_stamp);
      if (got.event_slot !== want.res.event_slot)
        fault("event_slot", want.res.event_slot, got.event_slot);
      if (last !== want.last)
        fault("last_of_frame", want.last, last);
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [InDataBits-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OutDataBits-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  key_event_scoreboard board = new(RingSlots);

  // no random idling on either side while set
  bit    calm = 1'b0;
  keys_t sent_keys = '0;
  int    idle_cycles = 0;

  key_edge_event_mapper #(
    .RING_SLOTS(RingSlots)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // idle length: mostly short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // drive one frame request and hold it until accepted
  task automatic send_frame(input keys_t keys, input logic [StampBits-1:0] stamp);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 30) gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, stamp, keys};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_frame(keys, stamp);
    sent_keys = keys;
  endtask

  // hold off requests until every expected result has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (board.posted.size() != 0) @(posedge clk_i);
  endtask

  // result side: check accepted results, stall at random
  initial begin : result_sink
    int stall;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tlast);
      if (stall > 0) stall--;
      else if (!calm && $urandom_range(0, 99) < 25) stall = gap_len();
      m_axis_tready <= (stall == 0);
    end
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    keys_t                keys;
    logic [StampBits-1:0] stamp;
    int                   r;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first frame posts no event although every key is held
    send_frame(7'h7F, 32'hFFFF_FFFF);
    // full release, full press, no edge, then full release again
    send_frame(7'h00, 32'h0000_0000);
    send_frame(7'h7F, 32'hAAAA_AAAA);
    send_frame(7'h7F, 32'h5555_5555);
    send_frame(7'h00, 32'h8000_0001);
    // one key at a time, Return last with no held bit
    for (int k = 0; k < KeyCount; k++) begin
      send_frame(keys_t'(1) << k, 32'h0000_1000 + k);
    end
    send_frame(7'h40, 32'h7FFF_FFFE);
    send_frame(7'h2A, 32'h1234_5678);
    send_frame(7'h55, 32'hFEDC_BA98);
    send_frame(7'h3F, 32'h0F0F_0F0F);
    send_frame(7'h40, 32'hF0F0_F0F0);
    wait_drained();

    // random frames: mostly few flipped keys with rising stamps
    stamp = $urandom();
    for (int b = 0; b < RandBlocks; b++) begin
      calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < BlockFrames; i++) begin
        r = $urandom_range(0, 99);
        if (r < 15) keys = sent_keys;
        else if (r < 55) keys = sent_keys ^ (keys_t'(1) << $urandom_range(0, 6));
        else if (r < 75) keys = sent_keys ^ (keys_t'(1) << $urandom_range(0, 6))
                                          ^ (keys_t'(1) << $urandom_range(0, 6));
        else keys = keys_t'($urandom_range(0, 127));
        if ($urandom_range(0, 4) == 0) stamp = $urandom();
        else stamp = stamp + $urandom_range(1, 40);
        send_frame(keys, stamp);
      end
      if (b == RandBlocks / 2) wait_drained();
    end
    calm = 1'b0;

    // let everything outstanding arrive, then a short quiet window
    s_axis_tvalid <= 1'b0;
    while (board.posted.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.errors == 0 && board.posted.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/kem_pkg.sv
rtl/key_edge_event_mapper.sv
rtl/kem_checker.sv
tb/key_edge_event_mapper_tb.sv
